### hw/rtl/dump_line_value_decoder_assert.svh
// assertion macros for the dump line value decoder
// used by the top level; relies on clk and arst_n in the including scope
`ifndef DUMP_LINE_VALUE_DECODER_ASSERT_SVH
`define DUMP_LINE_VALUE_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DLVD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DLVD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/dlvd_pkg.sv
// shared types, codes and helper functions of the dump line value decoder
// no dependencies
package dlvd_pkg;

	// line phases
	localparam logic [2:0] PH_LEADER = 3'd0;
	localparam logic [2:0] PH_MATCH  = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_FIRST  = 3'd3;
	localparam logic [2:0] PH_BODY   = 3'd4;
	localparam logic [2:0] PH_ESC1   = 3'd5;
	localparam logic [2:0] PH_ESC2   = 3'd6;
	localparam logic [2:0] PH_HEX2   = 3'd7;

	// result kinds
	localparam logic [2:0] KIND_BYTE    = 3'd0;
	localparam logic [2:0] KIND_END     = 3'd1;
	localparam logic [2:0] KIND_REPEAT  = 3'd2;
	localparam logic [2:0] KIND_DATAEND = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	// configuration register indexes
	localparam logic CFG_PRINT_FORMAT = 1'b0;
	localparam logic CFG_NO_HEADER    = 1'b1;

	// characters
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_D       = 8'h44;

	// last match position of the end marker tail after the leader
	localparam logic [2:0] END_LAST_POS = 3'd6;

	typedef struct packed {
		logic [2:0] phase;
		logic [3:0] high_nibble;
		logic [2:0] match_pos;
		logic       error_seen;
	} dlvd_state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] kind;
		logic [7:0] value_byte;
	} dlvd_result_t;

	localparam dlvd_state_t STATE_RESET = '{
		phase: PH_LEADER, high_nibble: 4'd0, match_pos: 3'd0, error_seen: 1'b0};

	// characters of "ATA=END" by match position
	function automatic logic [7:0] end_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = 8'h41;
			3'd1:    ch = 8'h54;
			3'd2:    ch = 8'h41;
			3'd3:    ch = 8'h3d;
			3'd4:    ch = 8'h45;
			3'd5:    ch = 8'h4e;
			3'd6:    ch = 8'h44;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

### hw/rtl/dump_line_value_decoder.sv
// Dump line value decoder, top level: takes one text byte per beat and gives at
// most one result beat (kind in tuser, decoded byte in tdata) per input beat.
// It sustains one byte per clock cycle while m_tready allows, with the combinational
// phase decoder between the input register and the result register; each result
// passes through both registers. A format error is reported once and then the block
// swallows all input until reset. Configuration is taken at once.
// depends on dlvd_pkg, dlvd_step and dump_line_value_decoder_assert.svh
`include "dump_line_value_decoder_assert.svh"

module dump_line_value_decoder (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic       cfg_addr,
	input  logic [0:0] cfg_data,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] value_byte
	output logic [2:0] m_tuser    // [2:0] kind
);
	import dlvd_pkg::*;

	logic         print_format_q;
	logic         no_header_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         adv_s1;
	dlvd_state_t  st_q;
	dlvd_state_t  st_nxt;
	dlvd_result_t res;
	logic         m_valid_q;
	logic [7:0]   m_byte_q;
	logic [2:0]   m_kind_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			print_format_q <= 1'b0;
			no_header_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_PRINT_FORMAT: print_format_q <= cfg_data[0];
				CFG_NO_HEADER:    no_header_q    <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// input register moves on when the result register is free or draining
	assign adv_s1   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// decode of the registered byte
	dlvd_step u_step (
		.cur          (st_q),
		.in_byte      (byte_s1),
		.print_format (print_format_q),
		.no_header    (no_header_q),
		.nxt          (st_nxt),
		.res          (res)
	);

	// line state advances with each decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= res.valid;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.valid) begin
			m_kind_q <= res.kind;
			m_byte_q <= res.value_byte;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tuser  = m_kind_q;

	// checks
	`DLVD_ASSERT_NEXT(a_err_silent, st_q.error_seen && !m_valid_q, !m_valid_q,
		"result beat after sticky error")
	`DLVD_ASSERT_NOW(a_byte_zero, m_valid_q && m_kind_q != KIND_BYTE, m_byte_q == 8'd0,
		"nonzero byte on a non-byte result")
	`DLVD_ASSERT_NEXT(a_hold_s1, valid_s1 && !adv_s1, valid_s1 && $stable(byte_s1),
		"stalled input byte lost")

endmodule

### hw/rtl/dlvd_step.sv
// per-byte decode: next line state and at most one result for one input byte
// depends on dlvd_pkg
module dlvd_step (
	input  dlvd_pkg::dlvd_state_t  cur,
	input  logic [7:0]             in_byte,
	input  logic                   print_format,
	input  logic                   no_header,
	output dlvd_pkg::dlvd_state_t  nxt,
	output dlvd_pkg::dlvd_result_t res
);
	import dlvd_pkg::*;

	logic [2:0] ph;
	logic [4:0] hex;
	logic       printable;
	logic [2:0] after_value;

	assign hex         = hex_decode(in_byte);
	assign printable   = print_format | no_header;
	assign after_value = no_header ? PH_FIRST : PH_LEADER;
	// with no leader expected, the leader phase is the first value character
	assign ph = (cur.phase == PH_LEADER && no_header) ? PH_FIRST : cur.phase;

	// phase decoder
	always_comb begin
		nxt = cur;
		res = '0;
		if (!cur.error_seen) begin
			nxt.phase = ph;
			unique case (ph) inside
				PH_LEADER: begin
					if (in_byte == CH_SPACE) begin
						nxt.phase = PH_FIRST;
					end else if (in_byte == CH_D) begin
						nxt.phase     = PH_MATCH;
						nxt.match_pos = 3'd0;
					end else begin
						nxt.error_seen = 1'b1;
						res = '{valid: 1'b1, kind: KIND_ERROR, value_byte: 8'd0};
					end
				end
				PH_MATCH: begin
					if (cur.match_pos > END_LAST_POS || in_byte != end_char(cur.match_pos)) begin
						nxt.error_seen = 1'b1;
						res = '{valid: 1'b1, kind: KIND_ERROR, value_byte: 8'd0};
					end else if (cur.match_pos == END_LAST_POS) begin
						nxt.match_pos = 3'd0;
						nxt.phase     = PH_SKIP;
						res = '{valid: 1'b1, kind: KIND_DATAEND, value_byte: 8'd0};
					end else begin
						nxt.match_pos = cur.match_pos + 3'd1;
					end
				end
				PH_SKIP: begin
					if (in_byte == CH_NL) begin
						nxt.phase = PH_LEADER;
					end
				end
				PH_FIRST, PH_BODY: begin
					if (ph == PH_FIRST && in_byte == CH_SPACE) begin
						res = '{valid: 1'b1, kind: KIND_REPEAT, value_byte: 8'd0};
					end else if (in_byte == CH_NL) begin
						nxt.phase = after_value;
						res = '{valid: 1'b1, kind: KIND_END, value_byte: 8'd0};
					end else if (printable) begin
						if (in_byte == CH_BSLASH) begin
							nxt.phase = PH_ESC1;
						end else begin
							nxt.phase = PH_BODY;
							res = '{valid: 1'b1, kind: KIND_BYTE, value_byte: in_byte};
						end
					end else if (hex[4]) begin
						nxt.high_nibble = hex[3:0];
						nxt.phase       = PH_HEX2;
					end else begin
						nxt.error_seen = 1'b1;
						res = '{valid: 1'b1, kind: KIND_ERROR, value_byte: 8'd0};
					end
				end
				PH_ESC1: begin
					if (in_byte == CH_BSLASH) begin
						nxt.phase = PH_BODY;
						res = '{valid: 1'b1, kind: KIND_BYTE, value_byte: CH_BSLASH};
					end else if (hex[4]) begin
						nxt.high_nibble = hex[3:0];
						nxt.phase       = PH_ESC2;
					end else begin
						nxt.error_seen = 1'b1;
						res = '{valid: 1'b1, kind: KIND_ERROR, value_byte: 8'd0};
					end
				end
				PH_ESC2, PH_HEX2: begin
					if (hex[4]) begin
						nxt.phase = PH_BODY;
						res = '{valid: 1'b1, kind: KIND_BYTE,
							value_byte: {cur.high_nibble, hex[3:0]}};
					end else begin
						nxt.error_seen = 1'b1;
						res = '{valid: 1'b1, kind: KIND_ERROR, value_byte: 8'd0};
					end
				end
				default: begin
					nxt.phase = PH_LEADER;
				end
			endcase
		end
	end

endmodule

### verif/testbench.sv
// self-checking testbench for the dump line value decoder: directed lines, random
// well-formed lines under every format setting, then one sticky format error
// depends on dlvd_pkg and the dump_line_value_decoder top level
module testbench;
	import dlvd_pkg::*;

	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int ITEMS_PER_SETTING = 150;
	localparam int SETTLE_CYCLES     = 6;
	localparam logic [55:0] DATA_END_TAIL = "ATA=END";

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_addr = CFG_PRINT_FORMAT;
	logic [0:0] cfg_data = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] value_byte
	logic [2:0] m_tuser;           // [2:0] kind

	// decoder state as predicted, plus the format registers as written
	logic [2:0] line_ph = PH_LEADER;
	logic [3:0] pair_hi = 4'd0;
	logic [2:0] tail_pos = 3'd0;
	logic       halted = 1'b0;
	logic       fmt_print = 1'b0;
	logic       fmt_nohdr = 1'b0;

	decoded_t pending_results[$];
	decoded_t want;
	int       mismatches = 0;
	int       bytes_sent = 0;
	int       settings_used = 0;
	int       kind_seen[5] = '{default: 0};
	int       idle_cycles = 0;
	int       stall_left = 0;
	bit       idling_on = 1'b1;

	dump_line_value_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// character p of the end marker tail that follows the D leader
	function automatic logic [7:0] tail_char(input int p);
		return DATA_END_TAIL[8 * (6 - p) +: 8];
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	// hex digit text with random letter case
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] base;
		if (v < 10) return 8'h30 + v;
		base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
		return base + v - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
		return b;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// advance the predicted decoder by one byte and queue its result, if any
	task automatic track_byte(input logic [7:0] c);
		logic       hit;
		logic       body;
		logic [2:0] k;
		logic [7:0] v;
		int         h;
		hit = 1'b0;
		body = 1'b0;
		k = KIND_BYTE;
		v = 8'h00;
		if (!halted) begin
			if (line_ph == PH_LEADER && fmt_nohdr) line_ph = PH_FIRST;
			case (line_ph)
				PH_LEADER: begin
					if (c == CH_SPACE) begin
						line_ph = PH_FIRST;
					end else if (c == CH_D) begin
						line_ph = PH_MATCH;
						tail_pos = 3'd0;
					end else begin
						hit = 1'b1;
						k = KIND_ERROR;
					end
				end
				PH_MATCH: begin
					if (c != tail_char(int'(tail_pos))) begin
						hit = 1'b1;
						k = KIND_ERROR;
					end else if (tail_pos == END_LAST_POS) begin
						tail_pos = 3'd0;
						line_ph = PH_SKIP;
						hit = 1'b1;
						k = KIND_DATAEND;
					end else begin
						tail_pos = tail_pos + 3'd1;
					end
				end
				PH_SKIP: begin
					if (c == CH_NL) line_ph = PH_LEADER;
				end
				PH_FIRST: begin
					if (c == CH_SPACE) begin
						hit = 1'b1;
						k = KIND_REPEAT;
					end else begin
						line_ph = PH_BODY;
						body = 1'b1;
					end
				end
				PH_BODY: body = 1'b1;
				PH_ESC1: begin
					h = hex_digit(c);
					if (c == CH_BSLASH) begin
						line_ph = PH_BODY;
						hit = 1'b1;
						v = CH_BSLASH;
					end else if (h < 0) begin
						hit = 1'b1;
						k = KIND_ERROR;
					end else begin
						pair_hi = h[3:0];
						line_ph = PH_ESC2;
					end
				end
				default: begin
					// second digit of an escape or of a hex pair
					h = hex_digit(c);
					hit = 1'b1;
					if (h < 0) begin
						k = KIND_ERROR;
					end else begin
						line_ph = PH_BODY;
						v = {pair_hi, h[3:0]};
					end
				end
			endcase
			if (body) begin
				h = hex_digit(c);
				if (c == CH_NL) begin
					line_ph = fmt_nohdr ? PH_FIRST : PH_LEADER;
					hit = 1'b1;
					k = KIND_END;
				end else if (fmt_print || fmt_nohdr) begin
					if (c == CH_BSLASH) begin
						line_ph = PH_ESC1;
					end else begin
						hit = 1'b1;
						v = c;
					end
				end else if (h < 0) begin
					hit = 1'b1;
					k = KIND_ERROR;
				end else begin
					pair_hi = h[3:0];
					line_ph = PH_HEX2;
				end
			end
			if (hit && k == KIND_ERROR) halted = 1'b1;
			if (hit) pending_results.push_back('{kind: k, value: v});
		end
	endtask

	// one input beat, after a random gap; tvalid stays high across back-to-back beats
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idling_on ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		track_byte(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// drain all expected results, then let the pipeline empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_format(input logic pf, input logic nh);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_addr <= CFG_PRINT_FORMAT;
		cfg_data <= pf;
		@(posedge clk);
		cfg_addr <= CFG_NO_HEADER;
		cfg_data <= nh;
		@(posedge clk);
		cfg_we <= 1'b0;
		fmt_print = pf;
		fmt_nohdr = nh;
		settings_used++;
	endtask

	task automatic send_text_value(input int n);
		int         r;
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_byte(CH_BSLASH);
				send_byte(CH_BSLASH);
			end else if (r < 22) begin
				send_byte(CH_BSLASH);
				send_byte(hex_char(4'($urandom_range(0, 15))));
				send_byte(hex_char(4'($urandom_range(0, 15))));
			end else begin
				// a leading space would mean repeat, so keep it out of the first position
				do b = 8'($urandom_range(0, 255));
				while (b == CH_NL || b == CH_BSLASH || (i == 0 && b == CH_SPACE));
				send_byte(b);
			end
		end
	endtask

	// one well-formed line for the current format and line phase
	task automatic send_line();
		int         n;
		logic [7:0] b;
		if (!fmt_nohdr && line_ph == PH_LEADER) begin
			if ($urandom_range(0, 99) < 8) begin
				// end of data line with trailing junk
				send_byte(CH_D);
				for (int i = 0; i < 7; i++) send_byte(tail_char(i));
				repeat ($urandom_range(0, 5)) begin
					do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
					send_byte(b);
				end
				send_byte(CH_NL);
				return;
			end
			send_byte(CH_SPACE);
		end
		if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) send_byte(CH_SPACE);
		n = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 12);
		if (fmt_print || fmt_nohdr) begin
			send_text_value(n);
		end else begin
			repeat (n) begin
				send_byte(hex_char(4'($urandom_range(0, 15))));
				send_byte(hex_char(4'($urandom_range(0, 15))));
			end
		end
		send_byte(CH_NL);
	endtask

	task automatic test_directed();
		// printable: byte extremes, escaped backslash, hex escape, repeat, empty value, end marker
		set_format(1'b1, 1'b0);
		send_byte(CH_SPACE);
		send_byte(8'h00);
		send_byte(8'hff);
		send_text("\\\\\\aF\n");
		send_text("  \n");
		send_text("DATA=END\n");
		// hex pairs in both letter cases
		set_format(1'b0, 1'b0);
		send_text(" 0fF9\n");
		// no leader: empty value, then repeat and one byte
		set_format(1'b0, 1'b1);
		send_text("\n z\n");
	endtask

	task automatic test_random_lines();
		int stop_at;
		for (int setting = 0; setting < 6; setting++) begin
			case (setting)
				0: set_format(1'b0, 1'b0);
				1: set_format(1'b1, 1'b0);
				2: set_format(1'b0, 1'b1);
				3: set_format(1'b1, 1'b1);
				default: set_format(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
			// one stretch runs with no gaps or stalls at all
			idling_on = (setting != 4);
			stop_at = bytes_sent + ITEMS_PER_SETTING;
			while (bytes_sent < stop_at) send_line();
		end
		idling_on = 1'b1;
	endtask

	// an error halts the decoder for good, so only one flavor fits in a run
	task automatic test_sticky_error();
		int         flavor;
		int         k;
		logic [7:0] b;
		flavor = $urandom_range(0, 5);
		if (flavor == 2 || flavor == 3) set_format(1'b1, 1'($urandom_range(0, 1)));
		else if (flavor >= 4) set_format(1'b0, 1'b0);
		else set_format(1'($urandom_range(0, 1)), 1'b0);
		if (!fmt_nohdr && line_ph != PH_LEADER) send_byte(CH_NL);
		case (flavor)
			0: begin
				// bad leader, sometimes a bare newline
				do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_D);
				if ($urandom_range(0, 3) == 0) b = CH_NL;
				send_byte(b);
			end
			1: begin
				// end marker broken after a random number of good characters
				send_byte(CH_D);
				k = $urandom_range(0, 6);
				for (int i = 0; i < k; i++) send_byte(tail_char(i));
				do b = 8'($urandom_range(0, 255)); while (b == tail_char(k));
				if ($urandom_range(0, 3) == 0) b = CH_NL;
				send_byte(b);
			end
			2: begin
				// backslash followed by neither backslash nor hex
				if (!fmt_nohdr) send_byte(CH_SPACE);
				send_byte(CH_BSLASH);
				do b = non_hex(); while (b == CH_BSLASH);
				if ($urandom_range(0, 3) == 0) b = CH_NL;
				send_byte(b);
			end
			3: begin
				// escape with a bad second digit
				if (!fmt_nohdr) send_byte(CH_SPACE);
				send_byte(CH_BSLASH);
				send_byte(hex_char(4'($urandom_range(0, 15))));
				send_byte($urandom_range(0, 3) == 0 ? CH_NL : non_hex());
			end
			4: begin
				// non-hex character in byte format
				send_byte(CH_SPACE);
				if ($urandom_range(0, 1)) begin
					send_byte(hex_char(4'($urandom_range(0, 15))));
					send_byte(hex_char(4'($urandom_range(0, 15))));
				end
				do b = non_hex(); while (b == CH_NL || b == CH_SPACE);
				send_byte(b);
			end
			default: begin
				// unpaired digit in byte format
				send_byte(CH_SPACE);
				if ($urandom_range(0, 1)) begin
					send_byte(hex_char(4'($urandom_range(0, 15))));
					send_byte(hex_char(4'($urandom_range(0, 15))));
				end
				send_byte(hex_char(4'($urandom_range(0, 15))));
				send_byte($urandom_range(0, 1) ? CH_NL : non_hex());
			end
		endcase
		// everything after the error must be swallowed
		repeat (16) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("mismatch: %s", msg);
	endtask

	// result check against the oldest expected beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tuser <= KIND_ERROR) kind_seen[m_tuser]++;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected beat kind %0d byte %02h", m_tuser, m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.kind)
					note_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
				if (m_tdata !== want.value)
					note_mismatch($sformatf("byte %02h, expected %02h (kind %0d)",
						m_tdata, want.value, want.kind));
			end
		end
	end

	// result side stalls
	always @(posedge clk) begin
		if (stall_left > 0) stall_left = stall_left - 1;
		else if (idling_on) stall_left = idle_len();
		m_tready <= (stall_left == 0) || !idling_on;
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, pending_results.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_lines();
		test_sticky_error();
		wait_idle();
		$display("%0d input bytes over %0d format settings, ending in one sticky error",
			bytes_sent, settings_used);
		$display("results: %0d bytes, %0d value ends, %0d repeats, %0d data ends, %0d errors",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
		if (pending_results.size() != 0)
			$display("%0d expected results never arrived", pending_results.size());
		if (mismatches != 0) $display("%0d mismatches in total", mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
